// ===== hdl/nearest_color_recolor_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the nearest colour recolouring block
// Shared property wrappers, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef NEAREST_COLOR_RECOLOR_MACROS_SVH
`define NEAREST_COLOR_RECOLOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NCR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NCR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/ncr_pkg.sv =====
// ----------------------------------------------------------------------------
// ncr_pkg
// Types, register codes and helper functions of the nearest colour recolouring
// block.
// ----------------------------------------------------------------------------
`default_nettype none

package ncr_pkg;

	localparam int NUM_SLOTS = 6;
	localparam int ADDR_W    = 6;
	localparam int DATA_W    = 64;
	localparam int IDX_W     = 3;
	localparam int DIST_W    = 18;

	localparam logic [DIST_W-1:0] TOL_RESET = DIST_W'(40 * 40);
	localparam logic [7:0]         BYTE_MAX  = 8'd255;

	localparam logic [2:0] REG_ENTRY_COUNT = 3'd0;
	localparam logic [2:0] REG_TOLERANCE   = 3'd1;
	localparam logic [2:0] REG_ENTRY_0     = 3'd2;
	localparam logic [2:0] REG_ENTRY_1     = 3'd3;
	localparam logic [2:0] REG_ENTRY_2     = 3'd4;
	localparam logic [2:0] REG_ENTRY_3     = 3'd5;
	localparam logic [2:0] REG_ENTRY_4     = 3'd6;
	localparam logic [2:0] REG_ENTRY_5     = 3'd7;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	typedef struct packed {
		rgb_t src;
		rgb_t dst;
	} entry_t;

	typedef struct packed {
		logic [2:0]                   entry_count;
		logic [DIST_W-1:0]            tolerance;
		entry_t [NUM_SLOTS-1:0]       entry;
	} cfg_t;

	typedef struct packed {
		logic [7:0] pixel_red;
		logic [7:0] pixel_green;
		logic [7:0] pixel_blue;
		logic [7:0] pixel_alpha;
	} in_word_t;

	typedef struct packed {
		logic [7:0]       out_red;
		logic [7:0]       out_green;
		logic [7:0]       out_blue;
		logic [7:0]       out_alpha;
		logic             matched;
		logic [IDX_W-1:0] match_index;
	} out_word_t;

	function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
		abs_diff = (a > b) ? (a - b) : (b - a);
	endfunction

	function automatic logic [DIST_W-1:0] sq_dist(input rgb_t d);
		logic [15:0] rr;
		logic [15:0] gg;
		logic [15:0] bb;
		rr = 16'(d.r) * 16'(d.r);
		gg = 16'(d.g) * 16'(d.g);
		bb = 16'(d.b) * 16'(d.b);
		sq_dist = {2'b00, rr} + {2'b00, gg} + {2'b00, bb};
	endfunction

	function automatic logic [7:0] shift_sat(input logic [7:0] px, input logic [7:0] dst,
			input logic [7:0] src);
		logic [9:0] s;
		s = {2'b00, px} + {2'b00, dst} - {2'b00, src};
		if (s[9]) begin
			shift_sat = 8'd0;
		end else if (s[8]) begin
			shift_sat = BYTE_MAX;
		end else begin
			shift_sat = s[7:0];
		end
	endfunction

endpackage

`default_nettype wire

// ===== hdl/ncr_stream_if.sv =====
// ----------------------------------------------------------------------------
// ncr_stream_if
// Valid/ready stream channel carrying one word of a chosen type.
// ----------------------------------------------------------------------------
`default_nettype none

interface ncr_stream_if #(parameter type word_t = logic [7:0]);

	logic  valid;
	logic  ready;
	word_t word;

	modport source (output valid, output word, input ready);
	modport sink (input valid, input word, output ready);

endinterface

`default_nettype wire

// ===== hdl/ncr_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// ncr_cfg_regs
// APB register file holding the entry count, the tolerance and the six
// palette entries.
// ----------------------------------------------------------------------------
`default_nettype none

module ncr_cfg_regs
	import ncr_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = paddr[5:3];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.entry_count <= 3'd0;
			cfg_q.tolerance   <= TOL_RESET;
			cfg_q.entry       <= '0;
		end else if (wr_en) begin
			case (reg_sel)
				REG_ENTRY_COUNT: cfg_q.entry_count <= pwdata[2:0];
				REG_TOLERANCE:   cfg_q.tolerance   <= pwdata[DIST_W-1:0];
				REG_ENTRY_0:     cfg_q.entry[0]    <= pwdata[47:0];
				REG_ENTRY_1:     cfg_q.entry[1]    <= pwdata[47:0];
				REG_ENTRY_2:     cfg_q.entry[2]    <= pwdata[47:0];
				REG_ENTRY_3:     cfg_q.entry[3]    <= pwdata[47:0];
				REG_ENTRY_4:     cfg_q.entry[4]    <= pwdata[47:0];
				REG_ENTRY_5:     cfg_q.entry[5]    <= pwdata[47:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_ENTRY_COUNT: prdata = {61'd0, cfg_q.entry_count};
			REG_TOLERANCE:   prdata = {{(DATA_W-DIST_W){1'b0}}, cfg_q.tolerance};
			REG_ENTRY_0:     prdata = {16'd0, cfg_q.entry[0]};
			REG_ENTRY_1:     prdata = {16'd0, cfg_q.entry[1]};
			REG_ENTRY_2:     prdata = {16'd0, cfg_q.entry[2]};
			REG_ENTRY_3:     prdata = {16'd0, cfg_q.entry[3]};
			REG_ENTRY_4:     prdata = {16'd0, cfg_q.entry[4]};
			REG_ENTRY_5:     prdata = {16'd0, cfg_q.entry[5]};
			default:         prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== hdl/nearest_color_recolor.sv =====
// ----------------------------------------------------------------------------
// nearest_color_recolor
// Replaces each pixel's colour by shifting it towards the target of the
// nearest palette entry, when that entry lies within the tolerance.
// ----------------------------------------------------------------------------
// Pixels arrive on pixel_in, one RGBA word per handshake, and results leave
// on pixel_out with the recoloured RGB, the untouched alpha, a matched flag
// and the index of the matching entry.
// The palette, entry count and tolerance sit behind the APB port; the user must
// write them only while the stream is idle, as the block does not enforce it.
// The pipeline has four register stages: channel differences, squared
// distances, nearest-entry search and offset with saturation. One word is
// taken every cycle, limited by nothing but the handshakes.
// When the receiver stalls, each stage holds its word and pixel_in keeps
// accepting until every stage is full, so nothing is lost or repeated.
// Reset empties the pipeline at once, clears the entry count and the palette
// and loads a tolerance of 1600.
// ----------------------------------------------------------------------------
`default_nettype none

`include "nearest_color_recolor_macros.svh"

module nearest_color_recolor
	import ncr_pkg::*;
#(
	parameter int NUM_ENTRIES = 6
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	ncr_stream_if.sink             pixel_in,
	ncr_stream_if.source           pixel_out,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready
);

	localparam int LANES = NUM_ENTRIES;

	cfg_t cfg;

	ncr_cfg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	logic free_s1, free_s2, free_s3, free_s4;
	logic v_s1, v_s2, v_s3, v_s4;

	in_word_t          px_s1, px_s2, px_s3;
	rgb_t              diff_s1 [LANES];
	logic [LANES-1:0]  act_s1, act_s2;
	logic [DIST_W-1:0] dist_s2 [LANES];
	logic              matched_s3;
	logic [IDX_W-1:0]  idx_s3;
	out_word_t         out_s4;

	logic              found;
	logic [DIST_W-1:0] best_d;
	logic [IDX_W-1:0]  best_i;
	entry_t            sel_entry;
	out_word_t         out_c;
	rgb_t              px_rgb;

	assign free_s4 = !v_s4 || pixel_out.ready;
	assign free_s3 = !v_s3 || free_s4;
	assign free_s2 = !v_s2 || free_s3;
	assign free_s1 = !v_s1 || free_s2;

	assign pixel_in.ready  = free_s1;
	assign pixel_out.valid = v_s4;
	assign pixel_out.word  = out_s4;

	assign px_rgb = '{r: pixel_in.word.pixel_red, g: pixel_in.word.pixel_green,
		b: pixel_in.word.pixel_blue};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (free_s1) begin
				v_s1 <= pixel_in.valid;
			end
			if (free_s2) begin
				v_s2 <= v_s1;
			end
			if (free_s3) begin
				v_s3 <= v_s2;
			end
			if (free_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (free_s1) begin
			px_s1 <= pixel_in.word;
			for (int k = 0; k < LANES; k++) begin
				diff_s1[k].r <= abs_diff(cfg.entry[k].src.r, px_rgb.r);
				diff_s1[k].g <= abs_diff(cfg.entry[k].src.g, px_rgb.g);
				diff_s1[k].b <= abs_diff(cfg.entry[k].src.b, px_rgb.b);
				act_s1[k]    <= cfg.entry_count > 3'(k);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (free_s2) begin
			px_s2  <= px_s1;
			act_s2 <= act_s1;
			for (int k = 0; k < LANES; k++) begin
				dist_s2[k] <= sq_dist(diff_s1[k]);
			end
		end
	end

	always_comb begin
		found  = 1'b0;
		best_d = '0;
		best_i = '0;
		for (int k = 0; k < LANES; k++) begin
			if (act_s2[k] && (!found || dist_s2[k] < best_d)) begin
				found  = 1'b1;
				best_d = dist_s2[k];
				best_i = IDX_W'(k);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (free_s3) begin
			px_s3      <= px_s2;
			matched_s3 <= found && (best_d <= cfg.tolerance);
			idx_s3     <= best_i;
		end
	end

	assign sel_entry = cfg.entry[idx_s3];

	always_comb begin
		out_c.out_alpha = px_s3.pixel_alpha;
		if (matched_s3) begin
			out_c.out_red     = shift_sat(px_s3.pixel_red, sel_entry.dst.r, sel_entry.src.r);
			out_c.out_green   = shift_sat(px_s3.pixel_green, sel_entry.dst.g,
				sel_entry.src.g);
			out_c.out_blue    = shift_sat(px_s3.pixel_blue, sel_entry.dst.b, sel_entry.src.b);
			out_c.matched     = 1'b1;
			out_c.match_index = idx_s3;
		end else begin
			out_c.out_red     = px_s3.pixel_red;
			out_c.out_green   = px_s3.pixel_green;
			out_c.out_blue    = px_s3.pixel_blue;
			out_c.matched     = 1'b0;
			out_c.match_index = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (free_s4) begin
			out_s4 <= out_c;
		end
	end

	`NCR_ASSERT_NEXT(a_accept_lands, pixel_in.valid && pixel_in.ready, v_s1,
		"accepted word did not reach the first stage")
	`NCR_ASSERT_NOW(a_bubble_ready, !v_s1 || !v_s2 || !v_s3 || !v_s4, pixel_in.ready,
		"pipeline has an empty stage but refuses input")
	`NCR_ASSERT_NOW(a_index_range, v_s3 && matched_s3, idx_s3 < IDX_W'(LANES),
		"matched index lies beyond the palette lanes")
	`NCR_ASSERT_NOW(a_unmatched_index, v_s4 && !out_s4.matched, out_s4.match_index == '0,
		"unmatched word carries a non-zero index")

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the nearest colour recolouring block. A directed
// set of pixels covers reset values, saturation, ties, tolerance boundaries
// and the entry count limit. Randomised palettes and pixel streams with
// random idling and output stalls follow. Every pixel accepted is recoloured
// by a local predictor, and each output word is compared field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
	import ncr_pkg::*;

	localparam int NUM_ENTRIES = 6;
	localparam int QUIET_LIMIT = 2000;
	localparam int PHASES      = 12;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	ncr_stream_if #(.word_t(in_word_t))  pixel_in_ch ();
	ncr_stream_if #(.word_t(out_word_t)) pixel_out_ch ();

	nearest_color_recolor #(.NUM_ENTRIES(NUM_ENTRIES)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.pixel_in(pixel_in_ch),
		.pixel_out(pixel_out_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	logic [2:0]        count_mirror;
	logic [DIST_W-1:0] tol_mirror;
	entry_t            palette_mirror [NUM_ENTRIES];

	out_word_t   expected_pixels [$];
	int          mismatch_count   = 0;
	int          pixels_accepted  = 0;
	int          results_checked  = 0;
	int          palette_settings = 0;
	int          quiet_cycles     = 0;
	bit          src_idle_on      = 1'b1;
	bit          sink_idle_on     = 1'b1;
	int unsigned hold_len         = 0;
	int unsigned hold_ticket      = 0;
	int          count_plan [PHASES] = '{6, 7, 1, 3, 0, 5, 2, 4, 6, 7, 1, 6};

	always #10 clk = ~clk;

	function automatic logic [7:0] clip_byte(input int v);
		if (v < 0) begin
			return 8'd0;
		end else if (v > 255) begin
			return 8'd255;
		end
		return v[7:0];
	endfunction

	function automatic out_word_t recolour_pixel(input in_word_t px);
		out_word_t res;
		int        active;
		int        best_dist;
		int        best_idx;
		int        sq_sum;
		int        dr;
		int        dg;
		int        db;
		int        k;
		bit        found;
		active    = (count_mirror > NUM_ENTRIES) ? NUM_ENTRIES : int'(count_mirror);
		best_dist = 1 << 30;
		best_idx  = 0;
		found     = 1'b0;
		for (k = 0; k < active; k++) begin
			dr     = int'(palette_mirror[k].src.r) - int'(px.pixel_red);
			dg     = int'(palette_mirror[k].src.g) - int'(px.pixel_green);
			db     = int'(palette_mirror[k].src.b) - int'(px.pixel_blue);
			sq_sum = dr * dr + dg * dg + db * db;
			if (sq_sum < best_dist) begin
				best_dist = sq_sum;
				best_idx  = k;
				found     = 1'b1;
			end
		end
		res.out_alpha = px.pixel_alpha;
		if (found && best_dist <= int'(tol_mirror)) begin
			res.out_red   = clip_byte(int'(px.pixel_red) + int'(palette_mirror[best_idx].dst.r)
				- int'(palette_mirror[best_idx].src.r));
			res.out_green = clip_byte(int'(px.pixel_green) + int'(palette_mirror[best_idx].dst.g)
				- int'(palette_mirror[best_idx].src.g));
			res.out_blue  = clip_byte(int'(px.pixel_blue) + int'(palette_mirror[best_idx].dst.b)
				- int'(palette_mirror[best_idx].src.b));
			res.matched     = 1'b1;
			res.match_index = best_idx[IDX_W-1:0];
		end else begin
			res.out_red     = px.pixel_red;
			res.out_green   = px.pixel_green;
			res.out_blue    = px.pixel_blue;
			res.matched     = 1'b0;
			res.match_index = '0;
		end
		return res;
	endfunction

	function automatic logic [7:0] jitter(input logic [7:0] centre, input int spread);
		return clip_byte(int'(centre) + int'($urandom_range(2 * spread)) - spread);
	endfunction

	// Mostly pixels close to an active source colour, so that matches are common.
	function automatic in_word_t pick_pixel();
		in_word_t px;
		int       active;
		int       k;
		int       spread;
		px     = in_word_t'($urandom);
		active = (count_mirror > NUM_ENTRIES) ? NUM_ENTRIES : int'(count_mirror);
		if (active != 0 && $urandom_range(99) < 70) begin
			k      = $urandom_range(active - 1);
			spread = ($urandom_range(3) == 0) ? 0 : int'($urandom_range(45));
			px.pixel_red   = jitter(palette_mirror[k].src.r, spread);
			px.pixel_green = jitter(palette_mirror[k].src.g, spread);
			px.pixel_blue  = jitter(palette_mirror[k].src.b, spread);
		end
		return px;
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 40) begin
			$display("[%0t] mismatch: %s", $realtime, what);
		end
	endtask

	task automatic write_reg(input logic [2:0] reg_idx, input logic [DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_idx, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (reg_idx)
			REG_ENTRY_COUNT: count_mirror = value[2:0];
			REG_TOLERANCE:   tol_mirror   = value[DIST_W-1:0];
			default:         palette_mirror[reg_idx - REG_ENTRY_0] = value[47:0];
		endcase
		@(posedge clk);
	endtask

	task automatic write_entry(input int k, input rgb_t src, input rgb_t dst);
		write_reg(3'(REG_ENTRY_0 + k), {16'h0000, src, dst});
	endtask

	task automatic send_pixel(input in_word_t px);
		while (src_idle_on && $urandom_range(99) < 23) begin
			pixel_in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pixel_in_ch.valid <= 1'b1;
		pixel_in_ch.word  <= px;
		do @(posedge clk); while (!pixel_in_ch.ready);
	endtask

	task automatic wait_for_results();
		pixel_in_ch.valid <= 1'b0;
		do @(posedge clk); while (expected_pixels.size() != 0);
	endtask

	task automatic load_random_palette();
		logic [DATA_W-1:0] raw;
		entry_t            e;
		int                k;
		for (k = 0; k < NUM_ENTRIES; k++) begin
			raw = {$urandom, $urandom};
			e   = raw[47:0];
			if (k > 0 && $urandom_range(3) == 0) begin
				e.src = palette_mirror[$urandom_range(k - 1)].src;
			end
			if ($urandom_range(1) == 0) begin
				e.dst.r = jitter(e.src.r, 30);
				e.dst.g = jitter(e.src.g, 30);
				e.dst.b = jitter(e.src.b, 30);
			end
			write_reg(3'(REG_ENTRY_0 + k), {raw[63:48], e});
		end
	endtask

	task automatic test_passthrough_at_reset();
		send_pixel(32'h00000000);
		send_pixel(32'hFFFFFFFF);
		send_pixel(32'h28000080);
		wait_for_results();
	endtask

	task automatic test_directed_palette();
		write_reg(REG_ENTRY_COUNT, 64'd7);
		write_entry(0, 24'h0A0A0A, 24'h000000);
		write_entry(1, 24'hC8C8C8, 24'hFFFFFF);
		write_entry(2, 24'h643296, 24'h329664);
		write_entry(3, 24'h643296, 24'h000000);
		write_entry(4, 24'h00FF00, 24'hFF00FF);
		write_entry(5, 24'h808080, 24'h817F80);
		palette_settings++;
		send_pixel(32'h05050500);
		send_pixel(32'hD2DCE6FF);
		send_pixel(32'h64329607);
		send_pixel(32'h00FF0001);
		send_pixel(32'h828080C8);
		send_pixel(32'h45454545);
		send_pixel(32'hFF00FF03);
		send_pixel(32'hF0C8C810);
		send_pixel(32'hF0C9C811);
		wait_for_results();
		write_reg(REG_TOLERANCE, 64'd75);
		send_pixel(32'h05050520);
		wait_for_results();
		write_reg(REG_TOLERANCE, 64'd74);
		send_pixel(32'h05050521);
		wait_for_results();
		write_reg(REG_TOLERANCE, 64'h3FFFF);
		send_pixel(32'h45454522);
		send_pixel(32'hFF00FF23);
		wait_for_results();
		write_reg(REG_ENTRY_COUNT, 64'd1);
		write_reg(REG_TOLERANCE, 64'd195075);
		send_pixel(32'hFFFFFF24);
		send_pixel(32'h00000025);
		wait_for_results();
		write_reg(REG_ENTRY_COUNT, 64'd0);
		send_pixel(32'h0A0A0A26);
		wait_for_results();
		write_reg(REG_ENTRY_COUNT, 64'd6);
		write_reg(REG_TOLERANCE, {46'h0, TOL_RESET});
		palette_settings += 5;
	endtask

	// The output is held off while words keep coming, so the pipeline fills.
	task automatic test_output_stall();
		src_idle_on = 1'b0;
		hold_len    <= 60;
		hold_ticket <= hold_ticket + 1;
		repeat (40) send_pixel(pick_pixel());
		src_idle_on = 1'b1;
		wait_for_results();
	endtask

	task automatic test_pause_until_drained();
		repeat (25) send_pixel(pick_pixel());
		wait_for_results();
		repeat (25) send_pixel(pick_pixel());
		wait_for_results();
	endtask

	task automatic test_random_palettes();
		logic [DATA_W-1:0] raw;
		logic [DIST_W-1:0] tol;
		int                phase;
		for (phase = 0; phase < PHASES; phase++) begin
			wait_for_results();
			case (phase % 6)
				0:       tol = '0;
				1:       tol = TOL_RESET;
				2:       tol = DIST_W'($urandom_range(4000));
				3:       tol = DIST_W'(195075);
				4:       tol = '1;
				default: tol = DIST_W'($urandom_range(262143));
			endcase
			raw = {$urandom, $urandom};
			write_reg(REG_TOLERANCE, {raw[63:DIST_W], tol});
			write_reg(REG_ENTRY_COUNT, {raw[63:3], 3'(count_plan[phase])});
			load_random_palette();
			palette_settings++;
			if (phase == 5) begin
				src_idle_on  = 1'b0;
				sink_idle_on <= 1'b0;
			end
			repeat (155) send_pixel(pick_pixel());
			src_idle_on  = 1'b1;
			sink_idle_on <= 1'b1;
		end
		wait_for_results();
	endtask

	always @(posedge clk) begin
		out_word_t got;
		out_word_t want;
		if (pixel_out_ch.valid && pixel_out_ch.ready) begin
			got = pixel_out_ch.word;
			results_checked++;
			if (expected_pixels.size() == 0) begin
				report_mismatch($sformatf("output word %0h with nothing pending", got));
			end else begin
				want = expected_pixels.pop_front();
				if (got.out_red !== want.out_red)
					report_mismatch($sformatf("word %0d out_red %0d, predicted %0d",
						results_checked, got.out_red, want.out_red));
				if (got.out_green !== want.out_green)
					report_mismatch($sformatf("word %0d out_green %0d, predicted %0d",
						results_checked, got.out_green, want.out_green));
				if (got.out_blue !== want.out_blue)
					report_mismatch($sformatf("word %0d out_blue %0d, predicted %0d",
						results_checked, got.out_blue, want.out_blue));
				if (got.out_alpha !== want.out_alpha)
					report_mismatch($sformatf("word %0d out_alpha %0d, predicted %0d",
						results_checked, got.out_alpha, want.out_alpha));
				if (got.matched !== want.matched)
					report_mismatch($sformatf("word %0d matched %0b, predicted %0b",
						results_checked, got.matched, want.matched));
				if (got.match_index !== want.match_index)
					report_mismatch($sformatf("word %0d match_index %0d, predicted %0d",
						results_checked, got.match_index, want.match_index));
			end
		end
		if (pixel_in_ch.valid && pixel_in_ch.ready) begin
			pixels_accepted++;
			expected_pixels.push_back(recolour_pixel(pixel_in_ch.word));
		end
	end

	always @(posedge clk) begin
		int unsigned hold_left;
		int unsigned hold_seen;
		if (hold_ticket != hold_seen) begin
			hold_seen = hold_ticket;
			hold_left = hold_len;
		end
		if (hold_left != 0) begin
			hold_left--;
			pixel_out_ch.ready <= 1'b0;
		end else begin
			pixel_out_ch.ready <= !sink_idle_on || ($urandom_range(99) >= 23);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (pixel_in_ch.valid && pixel_in_ch.ready)
				|| (pixel_out_ch.valid && pixel_out_ch.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Timeout: %0d cycles without a handshake, %0d words pending",
					quiet_cycles, expected_pixels.size());
				$display("nearest_color_recolor verification failed");
				$finish;
			end
		end
	end

	initial begin
		pixel_in_ch.valid  <= 1'b0;
		pixel_in_ch.word   <= '0;
		psel               <= 1'b0;
		penable            <= 1'b0;
		pwrite             <= 1'b0;
		paddr              <= '0;
		pwdata             <= '0;
		count_mirror = '0;
		tol_mirror   = TOL_RESET;
		foreach (palette_mirror[k]) palette_mirror[k] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_passthrough_at_reset();
		test_directed_palette();
		test_output_stall();
		test_pause_until_drained();
		test_random_palettes();
		repeat (10) @(posedge clk);
		if (expected_pixels.size() != 0) begin
			report_mismatch($sformatf("%0d predicted words never arrived",
				expected_pixels.size()));
		end
		$display("Run covered %0d pixels and %0d output words over %0d palette settings.",
			pixels_accepted, results_checked, palette_settings);
		$display("Entry counts 0 to 7, tolerances 0 to full scale, ties, saturation and stalls.");
		if (mismatch_count == 0) begin
			$display("nearest_color_recolor verification clean");
		end else begin
			$display("nearest_color_recolor verification failed");
		end
		$finish;
	end

endmodule
